[rtl/wsvv_pkg.sv]
`timescale 1ns / 1ps
// types, constants and the saturation table for the weather sample vapor unit
// no dependencies

package wsvv_pkg;

    typedef logic [63:0] t_u64;

    // field widths
    localparam int unsigned T_W        = 16;
    localparam int unsigned H_W        = 16;
    localparam int unsigned P_W        = 18;
    localparam int unsigned K_W        = 16;
    localparam int unsigned V_W        = 16;
    localparam int unsigned CFG_W      = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_DATA_W  = ((T_W + H_W + P_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((P_W + K_W + V_W + 7) / 8) * 8;
    localparam int unsigned OUT_USER_W = 3;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TEMP_LOW      = 3'd0;
    localparam t_cfg_idx CFG_TEMP_HIGH     = 3'd1;
    localparam t_cfg_idx CFG_HUMIDITY_LOW  = 3'd2;
    localparam t_cfg_idx CFG_HUMIDITY_HIGH = 3'd3;
    localparam t_cfg_idx CFG_PRESSURE_LOW  = 3'd4;
    localparam t_cfg_idx CFG_PRESSURE_HIGH = 3'd5;

    // reset values
    localparam logic signed [T_W-1:0] TEMP_LOW_RST      = -16'sd9000;
    localparam logic signed [T_W-1:0] TEMP_HIGH_RST     = 16'sd3000;
    localparam logic [H_W-1:0]        HUMIDITY_LOW_RST  = 16'd0;
    localparam logic [H_W-1:0]        HUMIDITY_HIGH_RST = 16'd10000;
    localparam logic [P_W-1:0]        PRESSURE_LOW_RST  = 18'd40000;
    localparam logic [P_W-1:0]        PRESSURE_HIGH_RST = 18'd120000;
    localparam logic signed [T_W-1:0] LG_TEMP_RST       = 16'sd2000;
    localparam logic [H_W-1:0]        LG_HUMIDITY_RST   = 16'd5000;
    localparam logic [P_W-1:0]        LG_PRESSURE_RST   = 18'd100000;

    // table geometry
    localparam int unsigned TABLE_ENTRIES = 128;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned SAT_W         = 16;
    localparam int unsigned KELVIN_OFFSET = 27315;
    localparam int unsigned TBL_T_LO      = 17315;
    localparam int unsigned TBL_SPAN      = 15000;
    localparam int unsigned TC_CENTI      = 64730;
    localparam int unsigned SPAN_W        = $clog2(TBL_SPAN + 1);
    localparam int unsigned POS_W         = $clog2(TBL_SPAN * (TABLE_ENTRIES - 1) + 1);

    // interpolation and scaling datapath
    localparam longint unsigned MIX_MAX   = ((64'd1 << SAT_W) - 64'd1) * TBL_SPAN;
    localparam int unsigned MIX_W         = $clog2(MIX_MAX + 1);
    localparam int unsigned MIX_HI_W      = SAT_W + 1;
    localparam int unsigned MIX_ACC_W     = MIX_HI_W + SPAN_W;
    localparam int unsigned PROD_W        = MIX_W + H_W;
    localparam int unsigned ACC_W         = PROD_W + 1;
    localparam longint unsigned VAP_DIV   = 64'(TBL_SPAN) * 64'd10000 / 64'd2;
    localparam longint unsigned VAP_RND   = VAP_DIV / 64'd2;
    localparam int unsigned VREM_W        = $clog2(VAP_DIV);

    localparam int unsigned MAX_STEPS_A   = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;
    localparam int unsigned MAX_STEPS_B   = (H_W > V_W) ? H_W : V_W;
    localparam int unsigned MAX_STEPS     = (MAX_STEPS_A > MAX_STEPS_B) ? MAX_STEPS_A
                                                                        : MAX_STEPS_B;
    localparam int unsigned CNT_W         = $clog2(MAX_STEPS);

    localparam logic signed [T_W+1:0] KELVIN_OFF_S = (T_W+2)'(KELVIN_OFFSET);
    localparam logic signed [K_W+1:0] TBL_LO_S     = (K_W+2)'(TBL_T_LO);
    localparam logic signed [K_W+1:0] TBL_SPAN_S   = (K_W+2)'(TBL_SPAN);
    localparam logic [SPAN_W-1:0]     SPAN_C       = SPAN_W'(TBL_SPAN);
    localparam logic [VREM_W-1:0]     VAP_DIV_C    = VREM_W'(VAP_DIV);
    localparam logic [ACC_W-1:0]      VAP_RND_C    = ACC_W'(VAP_RND);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KELV,
        ST_POS,
        ST_IDX,
        ST_TBL,
        ST_MIX,
        ST_HUM,
        ST_RND,
        ST_VAP,
        ST_OUT
    } t_state;

    // wagner saturation table, built at elaboration
    localparam t_u64 Q32_ONE  = 64'd1 << 32;
    localparam t_u64 Q32_HALF = 64'd1 << 31;
    localparam t_u64 PC_UNITS = 64'd110600000;
    localparam t_u64 WAG_DEN  = 64'(TC_CENTI) * 64'(TABLE_ENTRIES - 1);

    typedef logic [TABLE_ENTRIES-1:0][SAT_W-1:0] t_sat_table;

    // restoring long division, only evaluated while the table is built
    function automatic t_u64 udiv64(input t_u64 a, input t_u64 b);
        logic [64:0] rem;
        t_u64        q;
        int          k;
        rem = '0;
        q   = '0;
        for (k = 63; k >= 0; k--) begin
            rem = {rem[63:0], a[6'(k)]};
            if (rem >= {1'b0, b}) begin
                rem       = rem - {1'b0, b};
                q[6'(k)]  = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_u64 mulq(input t_u64 a, input t_u64 b);
        return (a * b + Q32_HALF) >> 32;
    endfunction

    function automatic t_u64 isqrt64(input t_u64 v_in);
        t_u64 v;
        t_u64 r;
        t_u64 b;
        int   k;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // e^-f, f in q32 below one
    function automatic t_u64 exp_neg_frac(input t_u64 f);
        logic signed [63:0] sum;
        t_u64               term;
        int                 n;
        sum  = $signed(Q32_ONE);
        term = Q32_ONE;
        for (n = 1; n <= 24; n++) begin
            term = udiv64((term * f) >> 32, t_u64'(n));
            if ((n & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : t_u64'(sum);
    endfunction

    function automatic t_u64 exp_neg(input t_u64 m);
        t_u64 half;
        t_u64 e1;
        t_u64 k;
        t_u64 res;
        int   j;
        half = exp_neg_frac(Q32_HALF);
        e1   = mulq(half, half);
        k    = m >> 32;
        res  = exp_neg_frac(m & 64'hFFFF_FFFF);
        if (k > 64) begin
            res = '0;
        end else begin
            for (j = 0; j < 64; j++) begin
                if (t_u64'(j) < k && res != 0) begin
                    res = mulq(res, e1);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [SAT_W-1:0] wagner_entry(input int unsigned idx);
        t_u64 num;
        t_u64 tau;
        t_u64 t2;
        t_u64 t3;
        t_u64 t6;
        t_u64 t15;
        t_u64 neg;
        t_u64 pos;
        t_u64 m;
        t_u64 v;
        num = 64'(TBL_T_LO) * 64'(TABLE_ENTRIES - 1) + 64'(idx) * 64'(TBL_SPAN);
        tau = Q32_ONE - udiv64(num << 32, WAG_DEN);
        t2  = (tau * tau) >> 32;
        t3  = (t2 * tau) >> 32;
        t6  = (t3 * t3) >> 32;
        t15 = (tau * isqrt64(tau << 32)) >> 32;
        neg = udiv64(64'd776451 * tau, 64'd100000) + udiv64(64'd277580 * t3, 64'd100000)
            + udiv64(64'd123303 * t6, 64'd100000);
        pos = udiv64(64'd145838 * t15, 64'd100000);
        m   = (neg > pos) ? udiv64((neg - pos) * WAG_DEN, num) : 64'd0;
        v   = (PC_UNITS * exp_neg(m) + Q32_HALF) >> 32;
        return (v > 64'd65535) ? {SAT_W{1'b1}} : v[SAT_W-1:0];
    endfunction

    function automatic t_sat_table build_sat_table();
        t_sat_table  tbl;
        int unsigned i;
        tbl = '0;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            tbl[IDX_W'(i)] = wagner_entry(i);
        end
        return tbl;
    endfunction

    localparam t_sat_table SAT_TABLE = build_sat_table();

endpackage

[rtl/weather_sample_validate_vapor_unit.sv]
`timescale 1ns / 1ps
// top level of the weather sample validator with water vapor pressure
// depends on wsvv_pkg for widths, states and the saturation table
//
// each request carries temperature, humidity and pressure; a reading outside
// its window is replaced by the last good one and flagged in tuser
// window registers are written through the cfg port; the user must do so only
// while the unit is idle, which the unit itself does not enforce
// the vapor pressure comes from a bit-serial sequencer: index divide, table
// interpolation multiply, humidity multiply and rounding divide, one bit per cycle
// a new request is taken only once the last result is in the output register,
// which lets the next request in while a result waits

module weather_sample_validate_vapor_unit
    import wsvv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // temperature_raw, humidity_raw, pressure_raw, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pressure_out, temperature_kelvin, vapor_pressure, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // temp_replaced, humidity_replaced, pressure_replaced
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    t_state r_state;
    t_state w_state_nx;
    logic [CNT_W-1:0] r_cnt;

    logic w_in_acc;
    logic w_out_load;
    logic w_last;
    logic w_s_ready;

    // window registers
    logic signed [T_W-1:0] r_temp_low;
    logic signed [T_W-1:0] r_temp_high;
    logic [H_W-1:0]        r_hum_low;
    logic [H_W-1:0]        r_hum_high;
    logic [P_W-1:0]        r_pres_low;
    logic [P_W-1:0]        r_pres_high;

    // last good readings
    logic signed [T_W-1:0] r_lg_temp;
    logic [H_W-1:0]        r_lg_hum;
    logic [P_W-1:0]        r_lg_pres;

    // input decode
    logic signed [T_W-1:0] w_t_in;
    logic [H_W-1:0]        w_h_in;
    logic [P_W-1:0]        w_p_in;
    logic                  w_t_ok;
    logic                  w_h_ok;
    logic                  w_p_ok;

    // working registers
    logic signed [T_W-1:0] r_temp;
    logic [H_W-1:0]        r_hum;
    logic [P_W-1:0]        r_pres;
    logic                  r_tr;
    logic                  r_hr;
    logic                  r_pr;
    logic [K_W-1:0]        r_tk;
    logic [SPAN_W-1:0]     r_rem;
    logic [IDX_W-1:0]      r_dlo;
    logic [SAT_W-1:0]      r_s0;
    logic [SAT_W-1:0]      r_s1;
    logic [SPAN_W-1:0]     r_w0;
    logic [SPAN_W-1:0]     r_w1;
    logic [PROD_W-1:0]     r_acc;
    logic [MIX_W-1:0]      r_mix;
    logic [VREM_W-1:0]     r_vrem;
    logic [V_W-1:0]        r_vlo;
    logic                  r_sat;

    // output register
    logic                  r_o_valid;
    logic [P_W-1:0]        r_o_pres;
    logic [K_W-1:0]        r_o_tk;
    logic [V_W-1:0]        r_o_vap;
    logic                  r_o_tr;
    logic                  r_o_hr;
    logic                  r_o_pr;

    // datapath combinational signals
    logic signed [T_W+1:0] w_tk_sum;
    logic [K_W-1:0]        w_tk;
    logic signed [K_W+1:0] w_d_sum;
    logic [SPAN_W-1:0]     w_d;
    logic [POS_W-1:0]      w_pos;
    logic [SPAN_W:0]       w_drem2;
    logic                  w_dge;
    logic [IDX_W-1:0]      w_idx_nx;
    logic [MIX_HI_W-1:0]   w_mix_add;
    logic [MIX_HI_W:0]     w_mix_sum;
    logic [MIX_ACC_W-1:0]  w_mix_nx;
    logic [MIX_W:0]        w_hum_sum;
    logic [ACC_W-1:0]      w_rnd;
    logic                  w_rnd_sat;
    logic [VREM_W:0]       w_vrem2;
    logic                  w_vge;

    // input decode and window checks
    always_comb begin
        w_t_in = $signed(i_s_axis_tdata[T_W-1:0]);
        w_h_in = i_s_axis_tdata[T_W+H_W-1:T_W];
        w_p_in = i_s_axis_tdata[T_W+H_W+P_W-1:T_W+H_W];
        w_t_ok = (w_t_in >= r_temp_low) && (w_t_in <= r_temp_high);
        w_h_ok = (w_h_in >= r_hum_low) && (w_h_in <= r_hum_high);
        w_p_ok = (w_p_in >= r_pres_low) && (w_p_in <= r_pres_high);
    end

    // next state
    always_comb begin
        w_state_nx = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_state_nx = ST_KELV;
                end
            end
            ST_KELV: w_state_nx = ST_POS;
            ST_POS:  w_state_nx = ST_IDX;
            ST_IDX: begin
                if (w_last) begin
                    w_state_nx = ST_TBL;
                end
            end
            ST_TBL:  w_state_nx = ST_MIX;
            ST_MIX: begin
                if (w_last) begin
                    w_state_nx = ST_HUM;
                end
            end
            ST_HUM: begin
                if (w_last) begin
                    w_state_nx = ST_RND;
                end
            end
            ST_RND:  w_state_nx = ST_VAP;
            ST_VAP: begin
                if (w_last) begin
                    w_state_nx = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    w_state_nx = ST_IDLE;
                end
            end
            default: w_state_nx = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_s_ready  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: w_s_ready = 1'b1;
            ST_OUT:  w_out_load = !r_o_valid || i_m_axis_tready;
            default: begin
                w_s_ready  = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
        w_in_acc = w_s_ready && i_s_axis_tvalid;
        w_last   = (r_cnt == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= w_state_nx;
            if (r_state != w_state_nx) begin
                case (w_state_nx)
                    ST_IDX:  r_cnt <= CNT_W'(IDX_W - 1);
                    ST_MIX:  r_cnt <= CNT_W'(SPAN_W - 1);
                    ST_HUM:  r_cnt <= CNT_W'(H_W - 1);
                    ST_VAP:  r_cnt <= CNT_W'(V_W - 1);
                    default: r_cnt <= '0;
                endcase
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // window registers and last good readings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_low  <= TEMP_LOW_RST;
            r_temp_high <= TEMP_HIGH_RST;
            r_hum_low   <= HUMIDITY_LOW_RST;
            r_hum_high  <= HUMIDITY_HIGH_RST;
            r_pres_low  <= PRESSURE_LOW_RST;
            r_pres_high <= PRESSURE_HIGH_RST;
            r_lg_temp   <= LG_TEMP_RST;
            r_lg_hum    <= LG_HUMIDITY_RST;
            r_lg_pres   <= LG_PRESSURE_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEMP_LOW:      r_temp_low  <= $signed(i_cfg_data[T_W-1:0]);
                    CFG_TEMP_HIGH:     r_temp_high <= $signed(i_cfg_data[T_W-1:0]);
                    CFG_HUMIDITY_LOW:  r_hum_low   <= i_cfg_data[H_W-1:0];
                    CFG_HUMIDITY_HIGH: r_hum_high  <= i_cfg_data[H_W-1:0];
                    CFG_PRESSURE_LOW:  r_pres_low  <= i_cfg_data[P_W-1:0];
                    CFG_PRESSURE_HIGH: r_pres_high <= i_cfg_data[P_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                if (w_t_ok) begin
                    r_lg_temp <= w_t_in;
                end
                if (w_h_ok) begin
                    r_lg_hum <= w_h_in;
                end
                if (w_p_ok) begin
                    r_lg_pres <= w_p_in;
                end
            end
        end
    end

    // datapath combinational steps
    always_comb begin
        w_tk_sum = {{2{r_temp[T_W-1]}}, r_temp} + KELVIN_OFF_S;
        w_tk     = w_tk_sum[T_W+1] ? '0 : w_tk_sum[K_W-1:0];

        w_d_sum = $signed({2'b00, r_tk}) - TBL_LO_S;
        if (w_d_sum < 0) begin
            w_d = '0;
        end else if (w_d_sum > TBL_SPAN_S) begin
            w_d = SPAN_C;
        end else begin
            w_d = w_d_sum[SPAN_W-1:0];
        end
        w_pos = POS_W'(w_d) * POS_W'(TABLE_ENTRIES - 1);

        // index divide step
        w_drem2 = {r_rem, r_dlo[IDX_W-1]};
        w_dge   = (w_drem2 >= {1'b0, SPAN_C});
        w_idx_nx = (r_dlo == IDX_W'(TABLE_ENTRIES - 1)) ? r_dlo : r_dlo + 1'b1;

        // interpolation multiply step
        w_mix_add = {1'b0, (r_w0[0] ? r_s0 : '0)} + {1'b0, (r_w1[0] ? r_s1 : '0)};
        w_mix_sum = {1'b0, r_acc[MIX_ACC_W-1:SPAN_W]} + {1'b0, w_mix_add};
        w_mix_nx  = {w_mix_sum, r_acc[SPAN_W-1:1]};

        // humidity multiply step
        w_hum_sum = {1'b0, r_acc[PROD_W-1:H_W]} + {1'b0, (r_hum[0] ? r_mix : '0)};

        // rounding and saturation
        w_rnd     = {1'b0, r_acc} + VAP_RND_C;
        w_rnd_sat = (w_rnd[ACC_W-1:V_W] >= (ACC_W-V_W)'(VAP_DIV));

        // vapor divide step
        w_vrem2 = {r_vrem, r_vlo[V_W-1]};
        w_vge   = (w_vrem2 >= {1'b0, VAP_DIV_C});
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_temp <= w_t_ok ? w_t_in : r_lg_temp;
            r_hum  <= w_h_ok ? w_h_in : r_lg_hum;
            r_pres <= w_p_ok ? w_p_in : r_lg_pres;
            r_tr   <= !w_t_ok;
            r_hr   <= !w_h_ok;
            r_pr   <= !w_p_ok;
        end
        case (r_state)
            ST_KELV: r_tk <= w_tk;
            ST_POS: begin
                r_rem <= SPAN_W'(w_pos >> IDX_W);
                r_dlo <= w_pos[IDX_W-1:0];
            end
            ST_IDX: begin
                r_rem <= w_dge ? SPAN_W'(w_drem2 - {1'b0, SPAN_C}) : w_drem2[SPAN_W-1:0];
                r_dlo <= {r_dlo[IDX_W-2:0], w_dge};
            end
            ST_TBL: begin
                r_s0  <= SAT_TABLE[r_dlo];
                r_s1  <= SAT_TABLE[w_idx_nx];
                r_w0  <= SPAN_C - r_rem;
                r_w1  <= r_rem;
                r_acc <= '0;
            end
            ST_MIX: begin
                r_w0 <= r_w0 >> 1;
                r_w1 <= r_w1 >> 1;
                if (w_last) begin
                    r_mix <= w_mix_nx[MIX_W-1:0];
                    r_acc <= '0;
                end else begin
                    r_acc <= PROD_W'(w_mix_nx);
                end
            end
            ST_HUM: begin
                r_acc <= {w_hum_sum, r_acc[H_W-1:1]};
                r_hum <= r_hum >> 1;
            end
            ST_RND: begin
                r_sat  <= w_rnd_sat;
                r_vrem <= w_rnd[V_W+VREM_W-1:V_W];
                r_vlo  <= w_rnd[V_W-1:0];
            end
            ST_VAP: begin
                r_vrem <= w_vge ? VREM_W'(w_vrem2 - {1'b0, VAP_DIV_C})
                                : w_vrem2[VREM_W-1:0];
                r_vlo  <= {r_vlo[V_W-2:0], w_vge};
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_o_pres <= r_pres;
            r_o_tk   <= r_tk;
            r_o_vap  <= r_sat ? {V_W{1'b1}} : r_vlo;
            r_o_tr   <= r_tr;
            r_o_hr   <= r_hr;
            r_o_pr   <= r_pr;
        end
    end

    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - P_W - K_W - V_W){1'b0}}, r_o_vap, r_o_tk, r_o_pres};
    assign o_m_axis_tuser  = {r_o_pr, r_o_hr, r_o_tr};

endmodule
